/* src/print_develop_phase_timer_macros.svh */
// Assertion macros of the print development phase timer RTL.
`ifndef PRINT_DEVELOP_PHASE_TIMER_MACROS_SVH
`define PRINT_DEVELOP_PHASE_TIMER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define PDPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdpt assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PDPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdpt assertion failed");

`else

`define PDPT_ASSERT_SAME(lbl, ante, cons)
`define PDPT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/pdpt_pkg.sv */
// Package with the types, codes and helper functions of the phase timer.
package pdpt_pkg;

    // Command codes carried in the input transaction.
    localparam logic [1:0] CMD_TIME  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DEVELOP   = 3'd0;
    localparam logic [2:0] CFG_STOP      = 3'd1;
    localparam logic [2:0] CFG_FIX       = 3'd2;
    localparam logic [2:0] CFG_FACTOR    = 3'd3;
    localparam logic [2:0] CFG_FACTORIAL = 3'd4;
    localparam logic [2:0] CFG_ENABLE    = 3'd5;

    localparam logic [15:0] TICKS_RESET = 16'd50;
    localparam logic [3:0]  FACTOR_RESET = 4'd2;
    localparam logic [3:0]  FACTOR_MIN = 4'd2;
    localparam logic [3:0]  FACTOR_MAX = 4'd10;
    localparam logic [15:0] MARK_NONE = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Metronome window: multiples of one second within the last ten seconds.
    localparam int unsigned METRO_STEP = 10;
    localparam int unsigned METRO_SLOTS = 10;
    localparam logic [15:0] METRO_WINDOW = 16'(METRO_STEP * METRO_SLOTS);

    // A multiple of 300 is a multiple of 4 whose quarter is a multiple of 75.
    // The quarter is tested by multiplying with the inverse of 75 modulo 2^14.
    localparam logic [13:0] INV75 = 14'd2403;
    localparam logic [13:0] LIM75 = 14'((2 ** 14 - 1) / 75);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_MEASURE = 3'd1,
        PH_DEV     = 3'd2,
        PH_STOP    = 3'd3,
        PH_FIX     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        SND_NONE   = 2'd0,
        SND_METRO  = 2'd1,
        SND_DOUBLE = 2'd2,
        SND_END    = 2'd3
    } sound_t;

    typedef struct packed {
        logic [15:0] develop_ticks;
        logic [15:0] stop_ticks;
        logic [15:0] fix_ticks;
        logic [3:0]  factor_value;
        logic        factorial_mode;
        logic        timer_enabled;
    } cfg_t;

    typedef struct packed {
        logic [15:0] counter;
        phase_t      phase;
        logic [15:0] sec_mark;
        logic [15:0] half_mark;
    } state_t;

    typedef struct packed {
        logic        cycle_done;
        sound_t      sound;
        phase_t      phase;
        logic [15:0] remaining;
    } result_t;

    // True for a nonzero multiple of ten ticks no larger than ten seconds.
    function automatic logic is_metro_mark(input logic [15:0] c);
        logic hit;
        hit = 1'b0;
        for (int unsigned k = 1; k <= METRO_SLOTS; k++)
        begin
            hit = hit | (c == 16'(k * METRO_STEP));
        end
        return hit && (c <= METRO_WINDOW);
    endfunction

    // True for a nonzero multiple of thirty seconds.
    function automatic logic is_halfminute_mark(input logic [15:0] c);
        logic [13:0] q;
        q = c[15:2] * INV75;
        return (c != 16'd0) && (c[1:0] == 2'b00) && (q <= LIM75);
    endfunction

endpackage

/* src/pdpt_cfg.sv */
// Configuration register bank of the phase timer.
module pdpt_cfg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_wdata,
    output pdpt_pkg::cfg_t cfg
);
    import pdpt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode one register write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEVELOP:   cfg_next.develop_ticks  = cfg_wdata;
                CFG_STOP:      cfg_next.stop_ticks     = cfg_wdata;
                CFG_FIX:       cfg_next.fix_ticks      = cfg_wdata;
                CFG_FACTOR:    cfg_next.factor_value   = cfg_wdata[3:0];
                CFG_FACTORIAL: cfg_next.factorial_mode = cfg_wdata[0];
                CFG_ENABLE:    cfg_next.timer_enabled  = cfg_wdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.develop_ticks  <= TICKS_RESET;
            cfg_reg.stop_ticks     <= TICKS_RESET;
            cfg_reg.fix_ticks      <= TICKS_RESET;
            cfg_reg.factor_value   <= FACTOR_RESET;
            cfg_reg.factorial_mode <= 1'b0;
            cfg_reg.timer_enabled  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/pdpt_step.sv */
// Combinational step of the phase timer: next state and result for one command.
module pdpt_step
(
    input  pdpt_pkg::cfg_t    cfg,
    input  pdpt_pkg::state_t  st,
    input  logic [1:0]        cmd,
    input  logic [7:0]        ticks,
    output pdpt_pkg::state_t  st_next,
    output pdpt_pkg::result_t res
);
    import pdpt_pkg::*;

    logic [3:0]  eff_factor;
    logic [19:0] dev_prod;
    logic [15:0] dev_target;
    logic [19:0] meas_prod;
    logic [15:0] meas_sat;
    logic [16:0] add_sum;
    logic [15:0] add_sat;
    logic [15:0] count_chk;
    logic        measuring;
    logic        add_only;
    logic        metro_hit;
    logic        half_hit;
    logic        end_hit;
    logic        start_act;
    sound_t      sound;
    logic        done;

    // Factor clamped to its legal range and the two products that use it.
    assign eff_factor = (cfg.factor_value < FACTOR_MIN) ? FACTOR_MIN :
                        (cfg.factor_value > FACTOR_MAX) ? FACTOR_MAX : cfg.factor_value;
    assign dev_prod   = 20'(cfg.develop_ticks) * 20'(eff_factor);
    assign dev_target = cfg.factorial_mode ? dev_prod[15:0] : cfg.develop_ticks;
    assign meas_prod  = 20'(st.counter) * 20'(eff_factor);
    assign meas_sat   = (meas_prod[19:16] != 4'd0) ? COUNT_MAX : meas_prod[15:0];

    // Counter movement: count up while measuring, count down otherwise.
    assign measuring = (st.phase == PH_MEASURE);
    assign add_only  = measuring && (ticks != 8'd0);
    assign add_sum   = {1'b0, st.counter} + 17'(ticks);
    assign add_sat   = add_sum[16] ? COUNT_MAX : add_sum[15:0];
    assign count_chk = measuring ? st.counter :
                       (16'(ticks) >= st.counter) ? 16'd0 : st.counter - 16'(ticks);

    // Sound and phase-end decisions on the updated counter.
    assign metro_hit = !measuring && is_metro_mark(count_chk) && (count_chk != st.sec_mark);
    assign half_hit  = !add_only && !metro_hit && is_halfminute_mark(count_chk) &&
                       (count_chk != st.half_mark);
    assign end_hit   = !measuring && (count_chk == 16'd0) &&
                       ((st.phase == PH_DEV) || (st.phase == PH_STOP) || (st.phase == PH_FIX));
    assign start_act = cfg.timer_enabled &&
                       ((st.phase == PH_IDLE) ||
                        (cfg.factorial_mode && (st.phase == PH_MEASURE)));

    // Next state of counter, phase and marks.
    always_comb
    begin
        st_next = st;
        unique case (cmd)
            CMD_TIME:
            begin
                if (add_only)
                begin
                    st_next.counter = add_sat;
                end
                else
                begin
                    st_next.counter = count_chk;
                    if (metro_hit)
                    begin
                        st_next.sec_mark = count_chk;
                    end
                    if (half_hit)
                    begin
                        st_next.half_mark = count_chk;
                    end
                    if (end_hit)
                    begin
                        st_next.sec_mark  = MARK_NONE;
                        st_next.half_mark = MARK_NONE;
                        unique case (st.phase)
                            PH_DEV:
                            begin
                                st_next.phase   = PH_STOP;
                                st_next.counter = cfg.stop_ticks;
                            end
                            PH_STOP:
                            begin
                                st_next.phase   = PH_FIX;
                                st_next.counter = cfg.fix_ticks;
                            end
                            default:
                            begin
                                st_next.phase   = PH_IDLE;
                                st_next.counter = dev_target;
                            end
                        endcase
                    end
                end
            end
            CMD_START:
            begin
                if (start_act)
                begin
                    st_next.sec_mark  = MARK_NONE;
                    st_next.half_mark = MARK_NONE;
                    if (!cfg.factorial_mode)
                    begin
                        st_next.phase   = PH_DEV;
                        st_next.counter = cfg.develop_ticks;
                    end
                    else if (st.phase == PH_IDLE)
                    begin
                        st_next.phase   = PH_MEASURE;
                        st_next.counter = 16'd0;
                    end
                    else
                    begin
                        st_next.phase   = PH_DEV;
                        st_next.counter = meas_sat;
                    end
                end
            end
            CMD_RESET:
            begin
                st_next.phase     = PH_IDLE;
                st_next.counter   = cfg.factorial_mode ? 16'd0 : cfg.develop_ticks;
                st_next.sec_mark  = MARK_NONE;
                st_next.half_mark = MARK_NONE;
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

    // Sound and cycle-done flag of the result.
    always_comb
    begin
        sound = SND_NONE;
        done  = 1'b0;
        unique case (cmd)
            CMD_TIME:
            begin
                priority if (add_only)
                    sound = SND_NONE;
                else if (end_hit)
                    sound = SND_END;
                else if (metro_hit)
                    sound = SND_METRO;
                else if (half_hit)
                    sound = SND_DOUBLE;
                else
                    sound = SND_NONE;
                done = !add_only && end_hit && (st.phase == PH_FIX);
            end
            CMD_START:
            begin
                sound = start_act ? SND_DOUBLE : SND_NONE;
            end
            default:
            begin
                sound = SND_NONE;
            end
        endcase
    end

    assign res.remaining  = st_next.counter;
    assign res.phase      = st_next.phase;
    assign res.sound      = sound;
    assign res.cycle_done = done;

endmodule

/* src/print_develop_phase_timer.sv */
// Top level of the print development phase timer: stream ports, state and result register.
//
// Input stream s_*: one transaction is one command (time passed, start press or reset)
// with a tick batch in 100 ms units. Output stream m_*: exactly one result per command,
// carrying the counter, the phase, a sound code and a cycle-done pulse, in input order.
// Configuration: cfg_wr_en, cfg_index and cfg_wdata write one register per cycle.
// A command's result appears when it passes from the input to the result register.
// Throughput: one command per cycle unless a full result register meets a low m_tready.
// The input-to-result path is one step of the phase logic with two small 16 by 4
// multipliers and a 14 by 14 multiplier for the half-minute test.
// The input register keeps taking transactions while a finished result waits: it is
// free whenever its item moves on, so s_tready only falls when the result register is
// full and m_tready is low. A stalled result and the held input stay put until taken.
// Reset empties both registers, returns the timer to idle with a zero counter and
// cleared sound marks, and loads the configuration reset values.
`include "print_develop_phase_timer_macros.svh"

module print_develop_phase_timer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] command, [9:2] tick_count, [15:10] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] remaining, [18:16] phase, [20:19] sound,
                                   // [21] cycle_done, [23:22] zero
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import pdpt_pkg::*;

    cfg_t        cfg;
    logic        in_vld_reg;
    logic        in_vld_next;
    logic [1:0]  in_cmd_reg;
    logic [7:0]  in_ticks_reg;
    logic        out_vld_reg;
    logic        out_vld_next;
    result_t     out_res_reg;
    state_t      st_reg;
    state_t      st_next;
    result_t     step_res;
    logic        advance;
    logic        in_take;

    pdpt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdpt_step u_step
    (
        .cfg     (cfg),
        .st      (st_reg),
        .cmd     (in_cmd_reg),
        .ticks   (in_ticks_reg),
        .st_next (st_next),
        .res     (step_res)
    );

    // Handshake: the held command moves on when the result register can take it.
    assign advance      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready     = !in_vld_reg || advance;
    assign in_take      = s_tvalid && s_tready;
    assign in_vld_next  = in_take || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && !m_tready);

    // Valid flags and timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg          <= 1'b0;
            out_vld_reg         <= 1'b0;
            st_reg.counter      <= 16'd0;
            st_reg.phase        <= PH_IDLE;
            st_reg.sec_mark     <= MARK_NONE;
            st_reg.half_mark    <= MARK_NONE;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    // Payload registers of the input and result stages.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg   <= s_tdata[1:0];
            in_ticks_reg <= s_tdata[9:2];
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_res_reg.cycle_done, out_res_reg.sound,
                       out_res_reg.phase, out_res_reg.remaining};

    // A finished cycle always ends in idle with the phase-end sound.
    `PDPT_ASSERT_SAME(a_done_idle, out_vld_reg && out_res_reg.cycle_done, (out_res_reg.phase == PH_IDLE) && (out_res_reg.sound == SND_END))
    // Timer state only moves when a command passes to the result register.
    `PDPT_ASSERT_NEXT(a_state_hold, !advance, $stable(st_reg))
    // The metronome never runs while measuring, so its mark stays cleared.
    `PDPT_ASSERT_SAME(a_measure_mark, st_reg.phase == PH_MEASURE, st_reg.sec_mark == MARK_NONE)
    // A full input register that cannot move on blocks the input side.
    `PDPT_ASSERT_SAME(a_in_block, in_vld_reg && out_vld_reg && !m_tready, !s_tready)

endmodule
